[hw/rtl/pstb_pkg.sv]
`timescale 1ns / 1ps

package pstb_pkg;

	localparam int ID_W   = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TAKE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              active;
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] deadline;
		logic [DATA_W-1:0] pending;
	} slot_t;

	// due when (now - deadline) is non-negative as a signed value
	function automatic logic slot_due(input logic [DATA_W-1:0] now,
			input logic [DATA_W-1:0] deadline);
		logic [DATA_W-1:0] diff;
		diff = now - deadline;
		return ~diff[DATA_W-1];
	endfunction

	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] val);
		return (&val) ? val : val + DATA_W'(1);
	endfunction

endpackage

[hw/rtl/pstb_ram.sv]
`timescale 1ns / 1ps

module pstb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/periodic_soft_timer_bank.sv]
`timescale 1ns / 1ps

// Bank of NUM_TIMERS periodic millisecond timers. A tick advances the free-running
// millisecond count and then walks every slot of the slot table through its memory,
// which has one read and one write port: each slot costs a read, a load, one catch-up
// step for each period that has come due (at most CATCHUP_MAX per slot, 256 steps in
// all at the defaults) and a write-back of the slot into the table. One item is worked
// on at a time; a finished result sits in the output register and the next item can
// be accepted while it waits. Start with a zero period, and start, stop or take with
// an id of NUM_TIMERS or more, return status 1 and change nothing. Every result
// carries the millisecond count as it stands after the item.
module periodic_soft_timer_bank
	import pstb_pkg::*;
#(
	parameter int NUM_TIMERS  = 8,
	parameter int CATCHUP_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [ID_W-1:0]   timer_id,
	input  logic [DATA_W-1:0] period,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] taken_count,
	output logic              status,
	output logic [DATA_W-1:0] now_ms
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SW = $clog2(CATCHUP_MAX + 1);
	localparam int SLOT_W = $bits(slot_t);

	state_t state_q, state_d;
	op_t op_q;
	op_t in_op;
	logic [AW-1:0] idx_q;
	logic [DATA_W-1:0] millis_q;
	slot_t wk_slot_q;
	logic [SW-1:0] step_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic rd_valid_s1;
	logic [DATA_W-1:0] res_taken_q;
	logic res_status_q;
	logic out_valid_q;
	logic [DATA_W-1:0] out_taken_q;
	logic out_status_q;
	logic [DATA_W-1:0] out_now_q;

	logic in_xfer, id_ok, due, can_step, snap, last_slot, out_free;
	slot_t rd_slot, wr_slot;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;

	pstb_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(NUM_TIMERS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_slot),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign in_op     = op_t'(func);
	assign id_ok     = ({1'b0, timer_id} < (ID_W + 1)'(NUM_TIMERS));
	assign out_free  = !out_valid_q || out_ready;
	assign last_slot = (idx_q == AW'(NUM_TIMERS - 1));

	// never-written entries read as all zeros
	assign rd_slot = rd_valid_s1 ? slot_t'(ram_rdata) : '0;

	assign due      = slot_due(millis_q, wk_slot_q.deadline);
	assign can_step = wk_slot_q.active && (wk_slot_q.period != '0) && due
		&& (step_q < SW'(CATCHUP_MAX));
	assign snap     = (step_q == SW'(CATCHUP_MAX)) && due;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		wr_slot   = wk_slot_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (in_op)
						OP_TICK: state_d = ST_READ;
						OP_START: begin
							if (id_ok && (period != '0)) begin
								ram_we           = 1'b1;
								ram_waddr        = timer_id[AW-1:0];
								wr_slot.active   = 1'b1;
								wr_slot.period   = period;
								wr_slot.deadline = millis_q + period;
								wr_slot.pending  = '0;
							end
							state_d = ST_DONE;
						end
						default: state_d = id_ok ? ST_READ : ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (op_q == OP_TICK) begin
					state_d = ST_STEP;
				end else begin
					ram_we          = 1'b1;
					wr_slot         = rd_slot;
					wr_slot.pending = '0;
					if (op_q == OP_STOP) begin
						wr_slot.active = 1'b0;
					end
					state_d = ST_DONE;
				end
			end
			ST_STEP: begin
				if (!can_step) begin
					ram_we = 1'b1;
					if (snap) begin
						wr_slot.deadline = millis_q + wk_slot_q.period;
					end
					state_d = last_slot ? ST_DONE : ST_READ;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			millis_q    <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && (in_op == OP_TICK)) begin
				millis_q <= millis_q + DATA_W'(1);
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q         <= in_op;
			res_taken_q  <= '0;
			res_status_q <= ((in_op != OP_TICK) && !id_ok)
				|| ((in_op == OP_START) && (period == '0));
			idx_q        <= (in_op == OP_TICK) ? '0 : timer_id[AW-1:0];
		end
		if (ram_re) begin
			rd_valid_s1 <= valid_q[ram_raddr];
		end
		if (state_q == ST_LOAD) begin
			wk_slot_q <= rd_slot;
			step_q    <= '0;
			if (op_q == OP_TAKE) begin
				res_taken_q <= rd_slot.pending;
			end
		end
		if (state_q == ST_STEP) begin
			if (can_step) begin
				wk_slot_q.deadline <= wk_slot_q.deadline + wk_slot_q.period;
				wk_slot_q.pending  <= sat_inc(wk_slot_q.pending);
				step_q             <= step_q + SW'(1);
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_taken_q  <= res_taken_q;
			out_status_q <= res_status_q;
			out_now_q    <= millis_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign taken_count = out_taken_q;
	assign status      = out_status_q;
	assign now_ms      = out_now_q;

endmodule
